// ===== src/tsipdf_pkg.sv =====
// Package for the TSIP primary-timing deframer: framing bytes, status codes,
// and the result record type. No dependencies.
package tsipdf_pkg;

	localparam int CntW        = 5;
	localparam int MaxIndexDef = 20;
	localparam int CapN        = 8;
	localparam int CapIdxW     = $clog2(CapN);

	localparam logic [7:0] DleByte = 8'h10;
	localparam logic [7:0] EtxByte = 8'h03;
	localparam logic [7:0] IdByte  = 8'h8F;
	localparam logic [7:0] SubByte = 8'hAB;

	localparam logic [CntW-1:0] GoodLen  = CntW'(17);
	localparam logic [CntW-1:0] FirstCap = CntW'(9);
	localparam logic [CntW-1:0] LastCap  = CntW'(16);
	localparam logic [1:0]      UtcMask  = 2'b11;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_LEN   = 3'd1,
		ST_UTC   = 3'd2,
		ST_STUFF = 3'd3,
		ST_LONG  = 3'd4
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  flags;
		logic [7:0]  second;
		logic [7:0]  minute;
		logic [7:0]  hour;
		logic [7:0]  day;
		logic [7:0]  month;
		logic [15:0] year;
	} result_t;

endpackage

// ===== src/tsipdf_parser.sv =====
// Byte-level framing state machine and time-field capture for the deframer.
// Depends on tsipdf_pkg.
module tsipdf_parser import tsipdf_pkg::*; #(
	parameter int MAX_INDEX = MaxIndexDef
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       go,
	input  logic [7:0] rx_byte,
	output logic       has_result,
	output result_t    result
);

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_ID   = 3'd1,
		PH_SUB  = 3'd2,
		PH_BODY = 3'd3,
		PH_ESC  = 3'd4
	} phase_t;

	localparam logic [CntW-1:0] MaxIdx = CntW'(MAX_INDEX);

	phase_t              phase_q, phase_d;
	logic [CntW-1:0]     count_q, count_d;
	logic [7:0]          cap_q [CapN];
	logic                store;
	logic                emit;
	logic [CapIdxW-1:0]  cap_off;

	assign cap_off = CapIdxW'(count_q - FirstCap);

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		store   = 1'b0;
		emit    = 1'b0;
		result  = '0;
		result.status = ST_OK;
		case (phase_q)
			PH_HUNT: begin
				if (rx_byte == DleByte) phase_d = PH_ID;
			end
			PH_ID: begin
				phase_d = (rx_byte == IdByte) ? PH_SUB : PH_HUNT;
			end
			PH_SUB: begin
				if (rx_byte == SubByte) begin
					count_d = CntW'(1);
					phase_d = PH_BODY;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_BODY: begin
				if (rx_byte == DleByte) phase_d = PH_ESC;
				else store = 1'b1;
			end
			PH_ESC: begin
				if (rx_byte == DleByte) begin
					store = 1'b1;
				end else if (rx_byte != EtxByte) begin
					emit = 1'b1;
					result.status = ST_STUFF;
				end else if (count_q != GoodLen) begin
					emit = 1'b1;
					result.status = ST_LEN;
				end else if ((cap_q[0][1:0] & UtcMask) != UtcMask) begin
					emit = 1'b1;
					result.status = ST_UTC;
					result.flags  = cap_q[0];
				end else begin
					emit = 1'b1;
					result.status = ST_OK;
					result.flags  = cap_q[0];
					result.second = cap_q[1];
					result.minute = cap_q[2];
					result.hour   = cap_q[3];
					result.day    = cap_q[4];
					result.month  = cap_q[5];
					result.year   = {cap_q[6], cap_q[7]};
				end
			end
			default: begin
				phase_d = PH_HUNT;
				count_d = '0;
			end
		endcase
		// payload byte: abort on a byte at index MAX_INDEX
		if (store) begin
			if (count_q >= MaxIdx) begin
				emit = 1'b1;
				result.status = ST_LONG;
			end else begin
				count_d = count_q + CntW'(1);
				phase_d = PH_BODY;
			end
		end
		if (emit) begin
			phase_d = PH_HUNT;
			count_d = '0;
		end
	end

	assign has_result = emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			count_q <= '0;
		end else if (go) begin
			phase_q <= phase_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (go && store && count_q >= FirstCap && count_q <= LastCap) begin
			cap_q[cap_off] <= rx_byte;
		end
	end

endmodule

// ===== src/tsip_timing_packet_deframer.sv =====
// Top level of the TSIP primary-timing (0x8F-AB) packet deframer.
// Depends on tsipdf_pkg and tsipdf_parser.

// Takes one received serial byte per request and emits one result request at
// the end of each 0x8F-AB packet that got past the id and subcode bytes: a
// status (ok, wrong length, not UTC, stuffing error, overlong) with the time
// fields from payload indices 9..16. Fields other than timing_flags are zero
// in error results; timing_flags is also zero except for ok and not-UTC.
// Each byte is held in an input register, then the framing state machine
// updates and any result is loaded into the output register, from which it
// is presented until taken. One byte is taken every cycle; the only stall
// is a result that cannot be loaded while the output register still holds
// an untaken result.
module tsip_timing_packet_deframer import tsipdf_pkg::*; #(
	parameter int MAX_INDEX = MaxIndexDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [7:0]  timing_flags,
	output logic [7:0]  second_value,
	output logic [7:0]  minute_value,
	output logic [7:0]  hour_value,
	output logic [7:0]  day_value,
	output logic [7:0]  month_value,
	output logic [15:0] year_value
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	result_t    res_q;
	result_t    res;
	logic       has_result;
	logic       out_free;
	logic       go;

	// output slot is free if empty or being drained this cycle
	assign out_free = !out_valid_q || out_ready;
	// stage 1 advances unless it would need a busy output slot
	assign go       = valid_s1 && (!has_result || out_free);
	assign in_ready = !valid_s1 || go;

	tsipdf_parser #(
		.MAX_INDEX (MAX_INDEX)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (go),
		.rx_byte    (byte_s1),
		.has_result (has_result),
		.result     (res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) byte_s1 <= rx_byte;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && has_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && has_result) res_q <= res;
	end

	assign out_valid    = out_valid_q;
	assign status       = res_q.status;
	assign timing_flags = res_q.flags;
	assign second_value = res_q.second;
	assign minute_value = res_q.minute;
	assign hour_value   = res_q.hour;
	assign day_value    = res_q.day;
	assign month_value  = res_q.month;
	assign year_value   = res_q.year;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for tsip_timing_packet_deframer: byte-level framing
// predictor, random valid/ready idling on both sides. Depends on tsipdf_pkg.

module testbench;
	import tsipdf_pkg::*;

	localparam int MaxIdx      = MaxIndexDef;
	localparam int DrainCycles = 8;

	// framing phase of the local predictor
	typedef enum logic [2:0] {
		SEEK_DLE,
		SEEK_ID,
		SEEK_SUB,
		IN_BODY,
		AFTER_DLE
	} frame_phase_t;

	typedef logic [7:0] byte_q_t [$];

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic [7:0]  rx_byte   = 8'h00;
	logic        out_ready = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic [2:0]  status;
	logic [7:0]  timing_flags;
	logic [7:0]  second_value;
	logic [7:0]  minute_value;
	logic [7:0]  hour_value;
	logic [7:0]  day_value;
	logic [7:0]  month_value;
	logic [15:0] year_value;

	int send_idle_pct = 31;
	int recv_idle_pct = 71;
	int bytes_sent    = 0;
	int results_seen  = 0;
	int errors        = 0;

	// predictor state
	frame_phase_t frame_phase = SEEK_DLE;
	logic [4:0]   byte_count  = '0;
	logic [7:0]   time_bytes [CapN];
	result_t      timing_q [$];
	result_t      want_result;

	tsip_timing_packet_deframer #(
		.MAX_INDEX(MaxIdx)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.timing_flags(timing_flags),
		.second_value(second_value),
		.minute_value(minute_value),
		.hour_value(hour_value),
		.day_value(day_value),
		.month_value(month_value),
		.year_value(year_value)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	// ---------------- predictor ----------------

	task automatic post_result(input status_t st, input logic [7:0] fl, input bit with_time);
		result_t r;
		r        = '0;
		r.status = st;
		r.flags  = fl;
		if (with_time) begin
			r.second = time_bytes[1];
			r.minute = time_bytes[2];
			r.hour   = time_bytes[3];
			r.day    = time_bytes[4];
			r.month  = time_bytes[5];
			r.year   = {time_bytes[6], time_bytes[7]};
		end
		timing_q    = {timing_q, r};
		frame_phase = SEEK_DLE;
		byte_count  = '0;
	endtask

	// one unstuffed payload byte; aborts the frame on a byte at index MaxIdx
	task automatic keep_payload(input logic [7:0] b);
		if (byte_count >= FirstCap && byte_count <= LastCap)
			time_bytes[CapIdxW'(byte_count - FirstCap)] = b;
		if (byte_count >= MaxIdx) begin
			post_result(ST_LONG, 8'h00, 1'b0);
		end else begin
			byte_count  = byte_count + 1'b1;
			frame_phase = IN_BODY;
		end
	endtask

	task automatic predict_byte(input logic [7:0] b);
		case (frame_phase)
			SEEK_DLE: begin
				if (b == DleByte)
					frame_phase = SEEK_ID;
			end
			SEEK_ID: begin
				frame_phase = (b == IdByte) ? SEEK_SUB : SEEK_DLE;
			end
			SEEK_SUB: begin
				if (b == SubByte) begin
					byte_count  = 5'd1;	// subcode sits at index 0
					frame_phase = IN_BODY;
				end else begin
					frame_phase = SEEK_DLE;
				end
			end
			IN_BODY: begin
				if (b == DleByte)
					frame_phase = AFTER_DLE;
				else
					keep_payload(b);
			end
			AFTER_DLE: begin
				if (b == DleByte)
					keep_payload(b);
				else if (b != EtxByte)
					post_result(ST_STUFF, 8'h00, 1'b0);
				else if (byte_count != GoodLen)
					post_result(ST_LEN, 8'h00, 1'b0);
				else if ((time_bytes[0][1:0] & UtcMask) != UtcMask)
					post_result(ST_UTC, time_bytes[0], 1'b0);
				else
					post_result(ST_OK, time_bytes[0], 1'b1);
			end
			default: begin
				frame_phase = SEEK_DLE;
				byte_count  = '0;
			end
		endcase
	endtask

	// ---------------- driving ----------------

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// one request on the byte channel; prediction runs on acceptance
	task automatic send_byte(input logic [7:0] b);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
		predict_byte(b);
	endtask

	// header, stuffed body, and optionally the closing DLE ETX
	task automatic send_frame(input byte_q_t body, input bit close);
		send_byte(DleByte);
		send_byte(IdByte);
		send_byte(SubByte);
		foreach (body[i]) begin
			if (body[i] == DleByte)
				send_byte(DleByte);
			send_byte(body[i]);
		end
		if (close) begin
			send_byte(DleByte);
			send_byte(EtxByte);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (timing_q.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// 16 body bytes: filler for indices 1..8, then the time record
	function automatic byte_q_t timing_body(input logic [7:0] fill, input logic [7:0] flags,
			input logic [7:0] sec, input logic [7:0] mn, input logic [7:0] hr,
			input logic [7:0] dy, input logic [7:0] mo, input logic [15:0] yr);
		byte_q_t q;
		repeat (8) q = {q, fill};
		q = {q, flags, sec, mn, hr, dy, mo, yr[15:8], yr[7:0]};
		return q;
	endfunction

	// data byte biased toward DLE so stuffing is hit often
	function automatic logic [7:0] rand_data();
		return ($urandom_range(7) == 0) ? DleByte : 8'($urandom_range(255));
	endfunction

	function automatic byte_q_t rand_body(input int len);
		byte_q_t q;
		repeat (len) q = {q, rand_data()};
		return q;
	endfunction

	// ---------------- checking ----------------

	task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t mismatch on %s: expected %h, got %h", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_ready) begin
			results_seen++;
			if (timing_q.size() == 0) begin
				errors++;
				$display("%0t unexpected result: status %0d", $time, status);
			end else begin
				want_result = timing_q.pop_front();
				check_field("status", 16'(want_result.status), 16'(status));
				check_field("timing_flags", 16'(want_result.flags), 16'(timing_flags));
				check_field("second_value", 16'(want_result.second), 16'(second_value));
				check_field("minute_value", 16'(want_result.minute), 16'(minute_value));
				check_field("hour_value", 16'(want_result.hour), 16'(hour_value));
				check_field("day_value", 16'(want_result.day), 16'(day_value));
				check_field("month_value", 16'(want_result.month), 16'(month_value));
				check_field("year_value", want_result.year, year_value);
			end
		end
	end

	// ---------------- tests ----------------

	task automatic test_good_packets();
		send_frame(timing_body(8'h00, 8'h03, 8'd59, 8'd59, 8'd23, 8'd31, 8'd12, 16'd2024), 1'b1);
		send_frame(timing_body(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF), 1'b1);
		// DLE and ETX values as data, stuffed on the wire
		send_frame(timing_body(DleByte, 8'h13, DleByte, EtxByte, DleByte, EtxByte, DleByte,
			{DleByte, DleByte}), 1'b1);
		// flags with one or both UTC bits clear
		send_frame(timing_body(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000), 1'b1);
		send_frame(timing_body(8'h55, 8'hFE, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 16'h1234), 1'b1);
		send_frame(timing_body(8'hAA, 8'h01, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10, 16'h8000), 1'b1);
		send_frame(timing_body(8'h0F, 8'h12, 8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 16'h0001), 1'b1);
		wait_idle();
	endtask

	task automatic test_framing_errors();
		byte_q_t q;
		send_frame(q, 1'b1);                    // empty body
		send_frame(rand_body(15), 1'b1);        // one byte short
		send_frame(rand_body(17), 1'b1);        // one byte long
		send_frame(rand_body(MaxIdx - 1), 1'b1); // longest body that still closes
		// DLE followed by neither DLE nor ETX
		send_frame(rand_body(5), 1'b0);
		send_byte(DleByte);
		send_byte(8'h55);
		send_frame(q, 1'b0);
		send_byte(DleByte);
		send_byte(8'hFF);
		send_frame(rand_body(16), 1'b0);
		send_byte(DleByte);
		send_byte(8'h00);
		// overlong: abort on the byte at index MaxIdx, tail goes to the hunt
		q = rand_body(MaxIdx + 2);
		q[MaxIdx - 1] = 8'h44;
		send_frame(q, 1'b1);
		// overlong where the aborting byte is a stuffed DLE
		q = rand_body(MaxIdx);
		q[MaxIdx - 1] = DleByte;
		send_frame(q, 1'b0);
		wait_idle();
	endtask

	task automatic test_header_mismatch();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(DleByte);
		send_byte(8'h8E);             // wrong id
		send_byte(DleByte);
		send_byte(IdByte);
		send_byte(8'hAA);             // wrong subcode
		// a DLE in the id slot is a mismatch, not a new start
		send_byte(DleByte);
		send_byte(DleByte);
		send_byte(IdByte);
		send_byte(SubByte);
		send_byte(8'h22);
		send_byte(EtxByte);
		send_byte(DleByte);
		send_byte(IdByte);
		send_byte(DleByte);           // DLE in the subcode slot
		send_byte(SubByte);
		send_frame(timing_body(8'h31, 8'h07, 8'd30, 8'd15, 8'd12, 8'd28, 8'd2, 16'd2000), 1'b1);
		wait_idle();
	endtask

	task automatic send_random_frame();
		byte_q_t    body;
		int         kind;
		logic [7:0] b;
		kind = $urandom_range(99);
		if ($urandom_range(9) == 0)
			repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
		if (kind < 70) begin
			body = rand_body(16);
			if ($urandom_range(4) != 0)
				body[8] = body[8] | 8'h03;
			send_frame(body, 1'b1);
		end else if (kind < 80) begin
			send_frame(rand_body($urandom_range(0, MaxIdx + 4)), 1'b1);
		end else if (kind < 88) begin
			send_frame(rand_body($urandom_range(0, 18)), 1'b0);
			send_byte(DleByte);
			do b = 8'($urandom_range(255)); while (b == DleByte || b == EtxByte);
			send_byte(b);
		end else if (kind < 95) begin
			send_byte(DleByte);
			b = ($urandom_range(1) == 0) ? IdByte : 8'($urandom_range(255));
			send_byte(b);
			send_byte(($urandom_range(3) == 0) ? SubByte : 8'($urandom_range(255)));
			repeat ($urandom_range(0, 6)) send_byte(rand_data());
		end else begin
			repeat ($urandom_range(1, 8)) send_byte(rand_data());
		end
	endtask

	task automatic test_random(input int send_pct, input int recv_pct, input int n_bytes);
		int target;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		target        = bytes_sent + n_bytes;
		while (bytes_sent < target)
			send_random_frame();
		wait_idle();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_good_packets();
		test_framing_errors();
		test_header_mismatch();
		test_random(31, 71, 550);
		test_random(71, 31, 550);
		test_random(0, 0, 550);
		$display("summary: %0d bytes in, %0d results checked", bytes_sent, results_seen);
		$display("summary: good, not-UTC, short/long, stuffing, overlong and header-miss frames");
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
